// ===== design/ttds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttds_pkg: shared types and tables for the twin tower dryer sequencer
// Request payloads, state codes, register indexes and transition tables.
// ----------------------------------------------------------------------------
package ttds_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int DRIVE_W         = 7;

    localparam logic [14:0] WET_TRIP_RST       = 15'd1400;
    localparam logic [14:0] DRY_TRIP_RST       = 15'd1000;
    localparam logic [15:0] PURGE_MS_RST       = 16'd2000;
    localparam logic [15:0] CONDITIONING_RST   = 16'd2000;
    localparam logic [15:0] CHECK_INTERVAL_RST = 16'd200;
    localparam logic        START_LEVEL_RST    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WET_TRIP       = 3'd0,
        REG_DRY_TRIP       = 3'd1,
        REG_PURGE_MS       = 3'd2,
        REG_CONDITIONING   = 3'd3,
        REG_CHECK_INTERVAL = 3'd4,
        REG_START_LEVEL    = 3'd5
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_FORCE = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_T1_DRY     = 4'd1,
        ST_T1_PURGE   = 4'd2,
        ST_T1_REGEN   = 4'd3,
        ST_T1_COND    = 4'd4,
        ST_T2_DRY     = 4'd5,
        ST_T2_PURGE   = 4'd6,
        ST_T2_REGEN   = 4'd7,
        ST_T2_COND    = 4'd8,
        ST_ERROR      = 4'd9
    } state_t;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] weight_grams;
        logic               start_request;
        logic [3:0]         force_target;
    } in_item_t;

    typedef struct packed {
        logic [3:0] current_state;
        logic [3:0] previous_state;
        logic       state_changed;
        logic       pump_one;
        logic       pump_two;
        logic       valve_one;
        logic       valve_two;
        logic       purge_lamp;
        logic       tower_one_lamp;
        logic       tower_two_lamp;
    } out_item_t;

    // Drive bits: 0 pump one, 1 pump two, 2 valve one, 3 valve two,
    // 4 purge lamp, 5 tower one lamp, 6 tower two lamp.
    function automatic logic [DRIVE_W-1:0] drive_mask(input state_t from);
        logic [DRIVE_W-1:0] m;
        unique case (from)
            ST_T1_REGEN, ST_T1_COND: m = 7'h2F;
            ST_T2_REGEN, ST_T2_COND: m = 7'h4F;
            default:                 m = 7'h1F;
        endcase
        return m;
    endfunction

    function automatic logic [DRIVE_W-1:0] drive_value(input state_t from);
        logic [DRIVE_W-1:0] v;
        unique case (from)
            ST_IDLE:     v = 7'h0E;
            ST_T1_DRY:   v = 7'h1F;
            ST_T1_PURGE: v = 7'h09;
            ST_T1_REGEN: v = 7'h2D;
            ST_T1_COND:  v = 7'h0D;
            ST_T2_DRY:   v = 7'h1F;
            ST_T2_PURGE: v = 7'h06;
            ST_T2_REGEN: v = 7'h4E;
            ST_T2_COND:  v = 7'h0E;
            default:     v = 7'h00;
        endcase
        return v;
    endfunction

    function automatic state_t next_code(input state_t from);
        state_t n;
        unique case (from)
            ST_IDLE:     n = ST_T1_DRY;
            ST_T1_DRY:   n = ST_T1_PURGE;
            ST_T1_PURGE: n = ST_T1_REGEN;
            ST_T1_REGEN: n = ST_T1_COND;
            ST_T1_COND:  n = ST_T2_DRY;
            ST_T2_DRY:   n = ST_T2_PURGE;
            ST_T2_PURGE: n = ST_T2_REGEN;
            ST_T2_REGEN: n = ST_T2_COND;
            ST_T2_COND:  n = ST_T1_DRY;
            default:     n = ST_ERROR;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== design/twin_tower_dryer_sequencer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twin_tower_dryer_sequencer_top: two-tower dryer phase sequencer
// Steps idle, then dry/purge/regenerate/condition on each tower in turn; force requests jump to any state up to error.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  s_        s_valid / s_ready   s_data  (in_item_t)
//  m_        m_valid / m_ready   m_data  (out_item_t)
//  cfg_      cfg_we              cfg_index, cfg_data
//
//  One result per request, in the next cycle; one request per clock while s_ready.
//  The next state and drive pattern come from one pass of logic into the
//  state and result registers; the result register alone sets latency.
//  s_ready is high while the result register is empty or being taken.
//  Reset: state idle, timers and drive levels zero, registers at defaults.
// ----------------------------------------------------------------------------
module twin_tower_dryer_sequencer_top
    import ttds_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire in_item_t               s_data,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      out_item_t              m_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    logic [14:0]            wet_trip_reg;
    logic [14:0]            dry_trip_reg;
    logic [15:0]            purge_ms_reg;
    logic [15:0]            conditioning_reg;
    logic [15:0]            check_interval_reg;
    logic                   start_level_reg;

    state_t                 state_reg, state_next;
    state_t                 prior_reg, prior_next;
    logic [TIMER_WIDTH-1:0] time_reg, time_next;
    logic [TIMER_WIDTH-1:0] ticks_reg, ticks_next;
    logic [DRIVE_W-1:0]     drive_reg, drive_next;
    logic                   changed;

    logic                   out_valid_reg;
    out_item_t              out_data_reg, out_data_next;

    logic                   accept;
    logic [TIMER_WIDTH-1:0] time_inc, ticks_inc;
    logic                   cond_met;
    logic signed [15:0]     wet_s, dry_s;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_trip_reg       <= WET_TRIP_RST;
            dry_trip_reg       <= DRY_TRIP_RST;
            purge_ms_reg       <= PURGE_MS_RST;
            conditioning_reg   <= CONDITIONING_RST;
            check_interval_reg <= CHECK_INTERVAL_RST;
            start_level_reg    <= START_LEVEL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WET_TRIP:       wet_trip_reg       <= cfg_data[14:0];
                REG_DRY_TRIP:       dry_trip_reg       <= cfg_data[14:0];
                REG_PURGE_MS:       purge_ms_reg       <= cfg_data;
                REG_CONDITIONING:   conditioning_reg   <= cfg_data;
                REG_CHECK_INTERVAL: check_interval_reg <= cfg_data;
                REG_START_LEVEL:    start_level_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign time_inc  = (time_reg == TIMER_MAX) ? time_reg : time_reg + 1'b1;
    assign ticks_inc = (ticks_reg == TIMER_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign wet_s     = $signed({1'b0, wet_trip_reg});
    assign dry_s     = $signed({1'b0, dry_trip_reg});

    always_comb begin
        unique case (state_reg)
            ST_IDLE:
                cond_met = (s_data.start_request == start_level_reg);
            ST_T1_DRY, ST_T2_DRY:
                cond_met = (s_data.weight_grams >= wet_s);
            ST_T1_PURGE, ST_T2_PURGE:
                cond_met = (CMP_W'(time_inc) >= CMP_W'(purge_ms_reg));
            ST_T1_REGEN, ST_T2_REGEN:
                cond_met = (s_data.weight_grams < dry_s);
            ST_T1_COND, ST_T2_COND:
                cond_met = (CMP_W'(time_inc) >= CMP_W'(conditioning_reg));
            default:
                cond_met = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        prior_next = prior_reg;
        time_next  = time_reg;
        ticks_next = ticks_reg;
        drive_next = drive_reg;
        changed    = 1'b0;
        if (s_data.operation == OP_FORCE) begin
            if (s_data.force_target <= ST_ERROR && s_data.force_target != state_reg) begin
                state_next = state_t'(s_data.force_target);
                prior_next = state_reg;
                time_next  = '0;
                changed    = 1'b1;
            end
        end else begin
            time_next  = time_inc;
            ticks_next = ticks_inc;
            if (CMP_W'(ticks_inc) >= CMP_W'(check_interval_reg)) begin
                ticks_next = '0;
                if (cond_met) begin
                    drive_next = (drive_reg & ~drive_mask(state_reg))
                                 | drive_value(state_reg);
                    state_next = next_code(state_reg);
                    prior_next = state_reg;
                    time_next  = '0;
                    changed    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_data_next.current_state  = state_next;
        out_data_next.previous_state = prior_next;
        out_data_next.state_changed  = changed;
        out_data_next.pump_one       = drive_next[0];
        out_data_next.pump_two       = drive_next[1];
        out_data_next.valve_one      = drive_next[2];
        out_data_next.valve_two      = drive_next[3];
        out_data_next.purge_lamp     = drive_next[4];
        out_data_next.tower_one_lamp = drive_next[5];
        out_data_next.tower_two_lamp = drive_next[6];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prior_reg     <= ST_IDLE;
            time_reg      <= '0;
            ticks_reg     <= '0;
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                prior_reg <= prior_next;
                time_reg  <= time_next;
                ticks_reg <= ticks_next;
                drive_reg <= drive_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
`default_nettype wire

// ===== sim/twin_tower_dryer_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twin_tower_dryer_sequencer_top_tb: request/result checker for the dryer
// Streams tick and force requests through the sequencer under several
// register settings and flow-control mixes, predicts each state, transition
// flag and drive pattern, and compares every result in order.
// ----------------------------------------------------------------------------
module twin_tower_dryer_sequencer_top_tb;
    import ttds_pkg::*;

    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_ITEMS   = 84;
    localparam logic [3:0]  BAD_TARGET_LO = 4'd10;
    localparam logic [3:0]  BAD_TARGET_HI = 4'd15;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies, at their reset values
    logic [14:0] cfg_wet   = 15'd1400;
    logic [14:0] cfg_dry   = 15'd1000;
    logic [15:0] cfg_purge = 16'd2000;
    logic [15:0] cfg_cond  = 16'd2000;
    logic [15:0] cfg_check = 16'd200;
    logic        cfg_start = 1'b1;

    // predicted sequencer state
    state_t      dry_state   = ST_IDLE;
    state_t      dry_prior   = ST_IDLE;
    logic [15:0] dwell_ms    = '0;
    logic [15:0] since_check = '0;
    logic [6:0]  drive_bits  = '0;

    in_item_t    pending_requests[$];
    out_item_t   expected_results[$];
    int unsigned requests_queued = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    bit          request_taken   = 1'b0;
    bit          recv_hold       = 1'b0;
    event        hold_off_go;

    twin_tower_dryer_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic bit move_to(state_t target);
        if (target == dry_state)
            return 1'b0;
        dry_prior = dry_state;
        dry_state = target;
        dwell_ms  = '0;
        return 1'b1;
    endfunction

    function automatic out_item_t advance_dryer(in_item_t req);
        out_item_t  res;
        bit         changed;
        bit         ready;
        int         weight;
        logic [6:0] mask;
        logic [6:0] value;
        state_t     from;
        changed = 1'b0;
        ready   = 1'b0;
        mask    = '0;
        value   = '0;
        weight  = $signed(req.weight_grams);
        if (req.operation == OP_FORCE) begin
            if (req.force_target <= ST_ERROR)
                changed = move_to(state_t'(req.force_target));
        end else begin
            if (dwell_ms != 16'hFFFF)
                dwell_ms = dwell_ms + 16'd1;
            if (since_check != 16'hFFFF)
                since_check = since_check + 16'd1;
            if (since_check >= cfg_check) begin
                since_check = '0;
                from = dry_state;
                case (from)
                    ST_IDLE: begin
                        ready = (req.start_request == cfg_start);
                        mask = 7'h1F; value = 7'h0E;
                    end
                    ST_T1_DRY: begin
                        ready = (weight >= int'(cfg_wet));
                        mask = 7'h1F; value = 7'h1F;
                    end
                    ST_T1_PURGE: begin
                        ready = (dwell_ms >= cfg_purge);
                        mask = 7'h1F; value = 7'h09;
                    end
                    ST_T1_REGEN: begin
                        ready = (weight < int'(cfg_dry));
                        mask = 7'h2F; value = 7'h2D;
                    end
                    ST_T1_COND: begin
                        ready = (dwell_ms >= cfg_cond);
                        mask = 7'h2F; value = 7'h0D;
                    end
                    ST_T2_DRY: begin
                        ready = (weight >= int'(cfg_wet));
                        mask = 7'h1F; value = 7'h1F;
                    end
                    ST_T2_PURGE: begin
                        ready = (dwell_ms >= cfg_purge);
                        mask = 7'h1F; value = 7'h06;
                    end
                    ST_T2_REGEN: begin
                        ready = (weight < int'(cfg_dry));
                        mask = 7'h4F; value = 7'h4E;
                    end
                    ST_T2_COND: begin
                        ready = (dwell_ms >= cfg_cond);
                        mask = 7'h4F; value = 7'h0E;
                    end
                    default: ready = 1'b0;
                endcase
                if (ready) begin
                    drive_bits = (drive_bits & ~mask) | value;
                    changed = move_to(from == ST_T2_COND ? ST_T1_DRY
                                                         : state_t'(from + 4'd1));
                end
            end
        end
        res.current_state  = dry_state;
        res.previous_state = dry_prior;
        res.state_changed  = changed;
        res.pump_one       = drive_bits[0];
        res.pump_two       = drive_bits[1];
        res.valve_one      = drive_bits[2];
        res.valve_two      = drive_bits[3];
        res.purge_lamp     = drive_bits[4];
        res.tower_one_lamp = drive_bits[5];
        res.tower_two_lamp = drive_bits[6];
        return res;
    endfunction

    function automatic in_item_t tick_req(logic [15:0] weight, logic start);
        in_item_t r;
        r.operation     = OP_TICK;
        r.weight_grams  = weight;
        r.start_request = start;
        r.force_target  = 4'($urandom_range(15));
        return r;
    endfunction

    function automatic in_item_t force_req(logic [3:0] target);
        in_item_t r;
        r.operation     = OP_FORCE;
        r.weight_grams  = 16'($urandom);
        r.start_request = 1'($urandom_range(1));
        r.force_target  = target;
        return r;
    endfunction

    // bias weights toward both trip points so the sequence keeps moving
    function automatic in_item_t random_request();
        int pick;
        int w;
        pick = $urandom_range(99);
        if (pick < 10)
            return force_req(4'($urandom_range(15)));
        case ($urandom_range(9))
            0, 1, 2, 3: w = $urandom_range(32767, int'(cfg_wet));
            4, 5, 6:    w = int'(cfg_dry) - 1 - $urandom_range(int'(cfg_dry) + 32767);
            7:          w = int'(cfg_wet) - $urandom_range(1);
            8:          w = int'(cfg_dry) - $urandom_range(1);
            default:    w = $urandom;
        endcase
        return tick_req(16'(w), 1'($urandom_range(1)));
    endfunction

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("dryer %s: expected state %0d prev %0d chg %0d drive %b, ",
                     what, want.current_state, want.previous_state,
                     want.state_changed, want[6:0],
                     "got state %0d prev %0d chg %0d drive %b",
                     got.current_state, got.previous_state,
                     got.state_changed, got[6:0]);
    endtask

    task automatic queue_request(input in_item_t r);
        pending_requests = {pending_requests, r};
        requests_queued++;
    endtask

    task automatic wait_drained();
        while (results_checked != requests_queued)
            @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(negedge aclk);
    endtask

    task automatic apply_settings(input int wet, input int dry, input int purge,
                                  input int cond, input int interval, input int level);
        cfg_wet   = wet[14:0];
        cfg_dry   = dry[14:0];
        cfg_purge = purge[15:0];
        cfg_cond  = cond[15:0];
        cfg_check = interval[15:0];
        cfg_start = level[0];
        write_reg(REG_WET_TRIP, wet);
        write_reg(REG_DRY_TRIP, dry);
        write_reg(REG_PURGE_MS, purge);
        write_reg(REG_CONDITIONING, cond);
        write_reg(REG_CHECK_INTERVAL, interval);
        write_reg(REG_START_LEVEL, level);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        int i;
        for (i = 0; i < count / 2; i++)
            queue_request(random_request());
        // pause the sender until the block has fully drained
        wait_drained();
        for (i = count / 2; i < count; i++)
            queue_request(random_request());
        wait_drained();
    endtask

    // driver: present the next request once the previous one is taken
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || request_taken)) begin
            request_taken = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_requests.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_off_go);
            @(posedge aclk);
            recv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            recv_hold = 1'b0;
        end
    end

    // monitor: check results against the oldest prediction, then predict
    always @(posedge aclk) begin
        out_item_t want;
        out_item_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                results_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.current_state  !== want.current_state  ||
                        got.previous_state !== want.previous_state ||
                        got.state_changed  !== want.state_changed  ||
                        got.pump_one       !== want.pump_one       ||
                        got.pump_two       !== want.pump_two       ||
                        got.valve_one      !== want.valve_one      ||
                        got.valve_two      !== want.valve_two      ||
                        got.purge_lamp     !== want.purge_lamp     ||
                        got.tower_one_lamp !== want.tower_one_lamp ||
                        got.tower_two_lamp !== want.tower_two_lamp)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (s_valid && s_ready) begin
                expected_results = {expected_results, advance_dryer(s_data)};
                request_taken = 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("twin_tower_dryer_sequencer_top test failed");
        $finish;
    end

    initial begin
        int k;
        int i;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: leave idle on the two hundredth tick
        for (i = 0; i < 205; i++)
            queue_request(tick_req(16'd0, 1'b1));
        wait_drained();

        // zero check interval: evaluate on every tick
        apply_settings(100, 50, 1, 0, 0, 0);
        queue_request(force_req(ST_IDLE));
        queue_request(tick_req(16'd0, 1'b1));
        queue_request(tick_req(16'h8000, 1'b0));
        queue_request(tick_req(16'd99, 1'b0));
        queue_request(tick_req(16'd100, 1'b1));
        queue_request(tick_req(16'h7FFF, 1'b0));
        queue_request(tick_req(16'd50, 1'b0));
        queue_request(tick_req(16'd49, 1'b0));
        queue_request(tick_req(16'd0, 1'b0));
        queue_request(tick_req(16'h7FFF, 1'b1));
        queue_request(tick_req(16'd0, 1'b0));
        queue_request(tick_req(16'h8000, 1'b0));
        queue_request(tick_req(16'd0, 1'b0));
        queue_request(force_req(ST_ERROR));
        queue_request(tick_req(16'h7FFF, 1'b1));
        queue_request(force_req(ST_ERROR));
        queue_request(force_req(BAD_TARGET_LO));
        queue_request(force_req(BAD_TARGET_HI));
        queue_request(force_req(ST_T2_COND));
        queue_request(force_req(ST_T1_PURGE));
        queue_request(force_req(ST_T1_COND));
        queue_request(force_req(ST_T2_DRY));
        queue_request(force_req(ST_T2_PURGE));
        queue_request(force_req(ST_T2_REGEN));
        queue_request(force_req(ST_T1_REGEN));
        queue_request(tick_req(16'hFFFF, 1'b0));
        wait_drained();

        for (k = 0; k < 8; k++) begin
            case (k)
                0: apply_settings(1400, 1000, 5, 5, 1, 1);
                1: apply_settings(0, 32767, 0, 0, 2, 0);
                2: apply_settings(32767, 0, 65535, 65535, 3, 1);
                4: apply_settings(300, 200, 3, 8, 1, 0);
                6: apply_settings(0, 0, 0, 0, 65535, 1);
                default: apply_settings($urandom_range(32767), $urandom_range(32767),
                                        $urandom_range(40), $urandom_range(40),
                                        $urandom_range(4, 1), $urandom_range(1));
            endcase
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // hold off the receiver while the sender keeps offering
            if (k == 4)
                -> hold_off_go;
            run_random_phase(PHASE_ITEMS);
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0 &&
            results_checked == requests_queued) begin
            $display("twin_tower_dryer_sequencer_top test passed");
        end else begin
            $display("twin_tower_dryer_sequencer_top test failed");
        end
        $finish;
    end

endmodule
